// ===== rtl/external_interrupt_and_service_call_macros.svh =====
// ----------------------------------------------------------------------------
// external_interrupt_and_service_call_macros
// Assertion macros shared by the external interrupt / service call RTL.
// ----------------------------------------------------------------------------
`ifndef EXTERNAL_INTERRUPT_AND_SERVICE_CALL_MACROS_SVH
`define EXTERNAL_INTERRUPT_AND_SERVICE_CALL_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked out of reset.
`define EISC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define EISC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define EISC_ASSERT_IMP(lbl, ante, cons, msg)
`define EISC_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/eisc_pkg.sv =====
// ----------------------------------------------------------------------------
// eisc_pkg
// Types and codes for the external interrupt and service call block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package eisc_pkg;

    // Request actions
    localparam logic [1:0] ACT_TICK       = 2'd0;
    localparam logic [1:0] ACT_SVC_CALL   = 2'd1;
    localparam logic [1:0] ACT_LOAD_TIMER = 2'd2;

    // Interrupt kinds
    localparam logic [1:0] INT_NONE    = 2'd0;
    localparam logic [1:0] INT_TIMER   = 2'd1;
    localparam logic [1:0] INT_CLKCMP  = 2'd2;
    localparam logic [1:0] INT_SERVICE = 2'd3;

    // Program check codes
    localparam logic [1:0] PC_NONE = 2'd0;
    localparam logic [1:0] PC_SPEC = 2'd1;
    localparam logic [1:0] PC_ADDR = 2'd2;

    // Condition codes
    localparam logic [1:0] CC_OK       = 2'd0;
    localparam logic [1:0] CC_SYNC     = 2'd1;
    localparam logic [1:0] CC_BAD_CMD  = 2'd2;
    localparam logic [1:0] CC_REJECTED = 2'd3;

    localparam logic [63:0] TIMER_DECREMENT  = 64'h0000_0000_0000_1000;
    localparam logic [31:0] PAGE_OFFSET_MASK = 32'h0000_0FFF;
    localparam logic [15:0] REQUIRED_LENGTH  = 16'd4096;
    localparam logic [31:0] CMD_READ_INFO    = 32'h0002_0001;
    localparam logic [31:0] MEM_SIZE_RESET   = 32'd67108864;

    // Subclass mask bit positions
    localparam int SUB_TIMER   = 0;
    localparam int SUB_CLKCMP  = 1;
    localparam int SUB_SERVICE = 2;

    typedef struct packed {
        logic [1:0]         action;
        logic [31:0]        svc_command;
        logic [31:0]        block_address;
        logic [15:0]        block_length;
        logic               sync_flag;
        logic [63:0]        tod_clock;
        logic [63:0]        clock_comparator;
        logic               ext_enabled;
        logic [2:0]         subclass_mask;
        logic signed [63:0] timer_load;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  cond_code;
        logic [1:0]  prog_check;
        logic [1:0]  int_kind;
        logic [31:0] ext_param;
    } t_out_item;

endpackage

// ===== rtl/eisc_exec.sv =====
// ----------------------------------------------------------------------------
// eisc_exec
// Architectural state and single-pass evaluation of one request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "external_interrupt_and_service_call_macros.svh"

module eisc_exec (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  eisc_pkg::t_in_item  i_item,
    input  logic [31:0]         i_mem_size,
    output eisc_pkg::t_out_item o_result
);
    import eisc_pkg::*;

    logic [63:0] r_cpu_timer;
    logic        r_pending;
    logic [31:0] r_param;

    logic [63:0] n_cpu_timer;
    logic        n_pending;
    logic [31:0] n_param;

    logic [63:0] timer_dec;
    t_out_item   res;

    assign timer_dec = r_cpu_timer - TIMER_DECREMENT;

    always_comb begin
        res         = '0;
        n_cpu_timer = r_cpu_timer;
        n_pending   = r_pending;
        n_param     = r_param;
        case (i_item.action)
            ACT_TICK: begin
                n_cpu_timer = timer_dec;
                if (i_item.ext_enabled && timer_dec[63] && i_item.subclass_mask[SUB_TIMER]) begin
                    res.int_kind = INT_TIMER;
                end else if (i_item.ext_enabled
                             && (i_item.tod_clock > i_item.clock_comparator)
                             && i_item.subclass_mask[SUB_CLKCMP]) begin
                    res.int_kind = INT_CLKCMP;
                end else if (i_item.ext_enabled && r_pending
                             && i_item.subclass_mask[SUB_SERVICE]) begin
                    res.int_kind  = INT_SERVICE;
                    res.ext_param = r_param;
                    n_pending     = 1'b0;
                end
            end
            ACT_SVC_CALL: begin
                if ((i_item.block_address & PAGE_OFFSET_MASK) != '0) begin
                    res.cond_code  = CC_REJECTED;
                    res.prog_check = PC_SPEC;
                end else if (i_item.block_address > i_mem_size) begin
                    res.cond_code  = CC_REJECTED;
                    res.prog_check = PC_ADDR;
                end else if (i_item.block_length != REQUIRED_LENGTH) begin
                    res.cond_code  = CC_REJECTED;
                    res.prog_check = PC_SPEC;
                end else if (i_item.svc_command != CMD_READ_INFO) begin
                    res.cond_code = CC_BAD_CMD;
                end else if (i_item.sync_flag) begin
                    res.cond_code = CC_SYNC;
                end else begin
                    res.cond_code = CC_OK;
                    n_param       = i_item.block_address;
                    n_pending     = 1'b1;
                end
            end
            ACT_LOAD_TIMER: begin
                n_cpu_timer = i_item.timer_load;
            end
            default: begin
                // unused action: no state change, all-zero result
            end
        endcase
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpu_timer <= '0;
            r_pending   <= 1'b0;
            r_param     <= '0;
        end else if (i_fire) begin
            r_cpu_timer <= n_cpu_timer;
            r_pending   <= n_pending;
            r_param     <= n_param;
        end
    end

    `EISC_ASSERT_NXT(a_svc_taken_clears,
        i_fire && (res.int_kind == INT_SERVICE), !r_pending,
        "service signal still pending after it was taken")
    `EISC_ASSERT_NXT(a_call_sets_pending,
        i_fire && (i_item.action == ACT_SVC_CALL) && (res.cond_code == CC_OK), r_pending,
        "accepted service call left no signal pending")
    `EISC_ASSERT_NXT(a_hold_when_idle,
        !i_fire, $stable(r_cpu_timer) && $stable(r_pending),
        "state moved without a request")

endmodule

// ===== rtl/external_interrupt_and_service_call.sv =====
// ----------------------------------------------------------------------------
// external_interrupt_and_service_call
// External interrupt source selection and service call acceptance.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel  : i_valid / o_stall / i_item. A request is taken at a rising
//                    edge with i_valid high and o_stall low.
//   Output channel : o_valid / i_stall / o_result. One result per request,
//                    delivered in request order, taken when o_valid is high and
//                    i_stall low.
//   Config         : i_cfg_we / i_cfg_wdata write the main storage size; write
//                    only while no request is in flight.
//   Path           : a taken request passes the input register, then the result
//                    register, before its result shows on o_result.
//   Throughput     : one request per cycle while i_stall is low. Timer decrement,
//                    TOD compare, address checks and interrupt priority pick all
//                    settle in the single logic stage between the two registers.
//   Reset          : synchronous, active low. Both stages empty, CPU timer,
//                    pending service signal and its parameter cleared, storage
//                    size back to 64 MiB.
//   Stall          : while i_stall holds a result, the result register keeps it
//                    and the input register keeps one more request; o_stall rises
//                    only when both are full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "external_interrupt_and_service_call_macros.svh"

module external_interrupt_and_service_call (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  eisc_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output eisc_pkg::t_out_item o_result,
    input  logic                i_cfg_we,
    input  logic [31:0]         i_cfg_wdata
);
    import eisc_pkg::*;

    // Input register stage
    logic      r_in_valid;
    t_in_item  r_in;

    // Result register stage
    logic      r_out_valid;
    t_out_item r_out;

    // Storage size register
    logic [31:0] r_mem_size;

    logic      advance;
    logic      fire;
    t_out_item exec_result;

    // The result register can load when it is empty or being drained.
    assign advance = !r_out_valid || !i_stall;
    // A request in the input register that cannot move on blocks the sender.
    assign o_stall = r_in_valid && !advance;
    assign fire    = r_in_valid && advance;

    eisc_exec u_exec (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_item     (r_in),
        .i_mem_size (r_mem_size),
        .o_result   (exec_result)
    );

    // Control: valid flags of both stages, storage size register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mem_size  <= MEM_SIZE_RESET;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (i_cfg_we) begin
                r_mem_size <= i_cfg_wdata;
            end
        end
    end

    // Payload: capture a new request, advance the evaluated result.
    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in <= i_item;
        end
        if (fire) begin
            r_out <= exec_result;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    `EISC_ASSERT_IMP(a_int_no_cc,
        o_valid && (o_result.int_kind != INT_NONE),
        (o_result.cond_code == CC_OK) && (o_result.prog_check == PC_NONE),
        "interrupt result carries a condition code")
    `EISC_ASSERT_IMP(a_param_only_svc,
        o_valid && (o_result.int_kind != INT_SERVICE), o_result.ext_param == '0,
        "external parameter set without a service signal")
    `EISC_ASSERT_IMP(a_pc_means_cc3,
        o_valid && (o_result.prog_check != PC_NONE), o_result.cond_code == CC_REJECTED,
        "program check without condition code 3")

endmodule

// ===== dv/tb_external_interrupt_and_service_call.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_external_interrupt_and_service_call
// Self-checking bench for the external interrupt / service call block. A
// directed burst walks the timer wrap, the interrupt priority, every service
// call rejection and a pending-signal overwrite. Random phases follow under
// several storage sizes and idle/stall mixes. A request-level predictor
// checks every result field in request order.
// ----------------------------------------------------------------------------
module tb_external_interrupt_and_service_call;
    import eisc_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int RESET_CYCLES = 6;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 10;
    // The block ignores this action code; it has no package name.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        o_stall;
    t_in_item    i_item      = '0;
    logic        o_valid;
    logic        i_stall     = 1'b0;
    t_out_item   o_result;
    logic        i_cfg_we    = 1'b0;
    logic [31:0] i_cfg_wdata = '0;

    // Predictor copy of the CPU state and the storage size register.
    logic signed [63:0] timer_mdl        = '0;
    logic               svc_pending_mdl  = 1'b0;
    logic [31:0]        svc_param_mdl    = '0;
    logic [31:0]        storage_size_mdl = MEM_SIZE_RESET;

    t_in_item  request_q[$];   // requests waiting for the driver
    t_out_item outcome_q[$];   // predicted results, oldest first

    logic req_taken      = 1'b0;
    int   n_queued       = 0;
    int   n_taken        = 0;
    int   n_fail         = 0;
    int   n_cycles       = 0;
    int   src_idle_pct   = 0;
    int   sink_stall_pct = 0;

    external_interrupt_and_service_call u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Advance the predicted state by one request and return its result.
    function automatic t_out_item compute_outcome(input t_in_item rq);
        t_out_item res;
        res = '0;
        case (rq.action)
            ACT_TICK: begin
                // Decrement wraps modulo 2^64; the sign bit decides a timer interrupt.
                timer_mdl = timer_mdl - TIMER_DECREMENT;
                if (rq.ext_enabled && timer_mdl[63] && rq.subclass_mask[SUB_TIMER]) begin
                    res.int_kind = INT_TIMER;
                end else if (rq.ext_enabled && (rq.tod_clock > rq.clock_comparator)
                             && rq.subclass_mask[SUB_CLKCMP]) begin
                    res.int_kind = INT_CLKCMP;
                end else if (rq.ext_enabled && svc_pending_mdl
                             && rq.subclass_mask[SUB_SERVICE]) begin
                    res.int_kind  = INT_SERVICE;
                    res.ext_param = svc_param_mdl;
                    svc_pending_mdl = 1'b0;
                end
            end
            ACT_SVC_CALL: begin
                if ((rq.block_address & PAGE_OFFSET_MASK) != '0) begin
                    res.cond_code  = CC_REJECTED;
                    res.prog_check = PC_SPEC;
                end else if (rq.block_address > storage_size_mdl) begin
                    res.cond_code  = CC_REJECTED;
                    res.prog_check = PC_ADDR;
                end else if (rq.block_length != REQUIRED_LENGTH) begin
                    res.cond_code  = CC_REJECTED;
                    res.prog_check = PC_SPEC;
                end else if (rq.svc_command != CMD_READ_INFO) begin
                    res.cond_code = CC_BAD_CMD;
                end else if (rq.sync_flag) begin
                    res.cond_code = CC_SYNC;
                end else begin
                    // A second accepted call simply overwrites the parameter.
                    svc_param_mdl   = rq.block_address;
                    svc_pending_mdl = 1'b1;
                    res.cond_code   = CC_OK;
                end
            end
            ACT_LOAD_TIMER: begin
                timer_mdl = rq.timer_load;
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    function automatic t_in_item pack_request(
        input logic [1:0]         action,
        input logic [31:0]        cmd,
        input logic [31:0]        addr,
        input logic [15:0]        len,
        input logic               sync,
        input logic [63:0]        tod,
        input logic [63:0]        clkc,
        input logic               ext,
        input logic [2:0]         mask,
        input logic signed [63:0] load
    );
        t_in_item rq;
        rq.action           = action;
        rq.svc_command      = cmd;
        rq.block_address    = addr;
        rq.block_length     = len;
        rq.sync_flag        = sync;
        rq.tod_clock        = tod;
        rq.clock_comparator = clkc;
        rq.ext_enabled      = ext;
        rq.subclass_mask    = mask;
        rq.timer_load       = load;
        return rq;
    endfunction

    task automatic push_request(input t_in_item rq);
        request_q.push_back(rq);
        n_queued++;
    endtask

    // Hold until every queued request is taken and every result has come back,
    // then let the two pipeline stages settle.
    task automatic drain();
        while (n_taken != n_queued || outcome_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write the storage size; only called with the block drained.
    task automatic write_storage_size(input logic [31:0] size);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= size;
        storage_size_mdl = size;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Random requests shaped so most service calls pass the early checks and
    // the timer often sits near zero. Pause at mid-phase until the block is empty.
    task automatic run_phase(input int count, input int src_pct, input int sink_pct);
        t_in_item    rq;
        int          pick;
        logic [31:0] top_page;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        for (int i = 0; i < count; i++) begin
            if (i == count / 2) begin
                drain();
            end
            rq.svc_command      = $urandom;
            rq.block_address    = $urandom;
            rq.block_length     = 16'($urandom_range(16'hFFFF));
            rq.sync_flag        = 1'($urandom_range(1));
            rq.tod_clock        = {$urandom, $urandom};
            rq.clock_comparator = {$urandom, $urandom};
            rq.ext_enabled      = ($urandom_range(99) < 80);
            rq.subclass_mask    = 3'($urandom_range(7));
            rq.timer_load       = {$urandom, $urandom};
            pick = $urandom_range(99);
            if (pick < 45) begin
                rq.action = ACT_TICK;
                case ($urandom_range(3))
                    0: rq.clock_comparator = rq.tod_clock;
                    1: rq.clock_comparator = rq.tod_clock - 64'd1;
                    default: begin
                    end
                endcase
            end else if (pick < 80) begin
                rq.action = ACT_SVC_CALL;
                if ($urandom_range(99) < 75) begin
                    // Well-formed call: page aligned and inside storage.
                    top_page = storage_size_mdl >> 12;
                    if ($urandom_range(9) == 0) begin
                        rq.block_address = storage_size_mdl & ~PAGE_OFFSET_MASK;
                    end else begin
                        rq.block_address = 32'($urandom_range(top_page)) << 12;
                    end
                    if ($urandom_range(9) != 0) rq.block_length = REQUIRED_LENGTH;
                    if ($urandom_range(9) != 0) rq.svc_command = CMD_READ_INFO;
                    rq.sync_flag = ($urandom_range(3) == 0);
                end else if ($urandom_range(1) == 0) begin
                    // Broken call that gets past the alignment check.
                    rq.block_address = rq.block_address & ~PAGE_OFFSET_MASK;
                    rq.block_length  = REQUIRED_LENGTH;
                end
            end else if (pick < 95) begin
                rq.action = ACT_LOAD_TIMER;
                case ($urandom_range(9))
                    0, 1, 2, 3: rq.timer_load = 64'($urandom_range(32'h8000));
                    4: rq.timer_load = 64'h8000_0000_0000_0000;
                    5: rq.timer_load = '0;
                    default: begin
                    end
                endcase
            end else begin
                rq.action = ACT_UNUSED;
            end
            push_request(rq);
        end
        drain();
    endtask

    // Driver: present a new request once the previous one was taken.
    // Idle decisions never look at o_stall; a stalled request holds.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || req_taken) begin
            if (request_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                i_item  <= request_q.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure.
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < sink_stall_pct);
    end

    // Request acceptance: predict the result as the block takes the request.
    always @(posedge i_clk) begin
        req_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall) begin
            outcome_q.push_back(compute_outcome(i_item));
            n_taken++;
        end
    end

    // Monitor: compare each taken result with the oldest prediction.
    always @(posedge i_clk) begin : result_monitor
        t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (outcome_q.size() == 0) begin
                n_fail++;
                if (n_fail <= MAX_REPORTS) begin
                    $display("unexpected result cc=%0d pc=%0d kind=%0d param=%h",
                             o_result.cond_code, o_result.prog_check,
                             o_result.int_kind, o_result.ext_param);
                end
            end else begin
                want = outcome_q.pop_front();
                if (o_result.cond_code !== want.cond_code
                    || o_result.prog_check !== want.prog_check
                    || o_result.int_kind !== want.int_kind
                    || o_result.ext_param !== want.ext_param) begin
                    n_fail++;
                    if (n_fail <= MAX_REPORTS) begin
                        $display({"result mismatch: cc %0d/%0d pc %0d/%0d",
                                  " kind %0d/%0d param %h/%h"},
                                 want.cond_code, o_result.cond_code,
                                 want.prog_check, o_result.prog_check,
                                 want.int_kind, o_result.int_kind,
                                 want.ext_param, o_result.ext_param);
                    end
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("FAIL external_interrupt_and_service_call");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed burst at the reset storage size (64 MiB), no idling.
        // Timer goes negative, but interrupts are disabled.
        push_request(pack_request(ACT_TICK, '0, '0, '0, 1'b0, '0, '0, 1'b0, 3'b111, '0));
        // Negative timer with its subclass enabled.
        push_request(pack_request(ACT_TICK, '0, '0, '0, 1'b0, '0, '0, 1'b1, 3'b001, '0));
        // Most negative timer wraps to positive on the next tick; the
        // comparator fires instead.
        push_request(pack_request(ACT_LOAD_TIMER, '0, '0, '0, 1'b0, '0, '0, 1'b0, 3'b000,
                                  64'sh8000_0000_0000_0000));
        push_request(pack_request(ACT_TICK, '0, '0, '0, 1'b0, 64'd1, 64'd0, 1'b1, 3'b011, '0));
        // Timer lands exactly on zero; equal TOD and comparator; nothing pending.
        push_request(pack_request(ACT_LOAD_TIMER, '0, '0, '0, 1'b0, '0, '0, 1'b0, 3'b000,
                                  64'sh1000));
        push_request(pack_request(ACT_TICK, '1, '1, '1, 1'b1, '1, '1, 1'b1, 3'b111, '0));
        // Service call rejections, in check order.
        push_request(pack_request(ACT_SVC_CALL, CMD_READ_INFO, 32'h0000_1001, REQUIRED_LENGTH,
                                  1'b0, '0, '0, 1'b0, 3'b000, '0));
        push_request(pack_request(ACT_SVC_CALL, CMD_READ_INFO, 32'h0400_1000, REQUIRED_LENGTH,
                                  1'b0, '0, '0, 1'b0, 3'b000, '0));
        push_request(pack_request(ACT_SVC_CALL, CMD_READ_INFO, 32'h0400_0000, 16'd4095,
                                  1'b0, '0, '0, 1'b0, 3'b000, '0));
        push_request(pack_request(ACT_SVC_CALL, 32'h0002_0002, 32'h0400_0000, REQUIRED_LENGTH,
                                  1'b0, '0, '0, 1'b0, 3'b000, '0));
        push_request(pack_request(ACT_SVC_CALL, CMD_READ_INFO, 32'h0400_0000, REQUIRED_LENGTH,
                                  1'b1, '0, '0, 1'b0, 3'b000, '0));
        // Accepted call, then a second one overwrites the pending parameter
        // (address equal to the storage size is allowed).
        push_request(pack_request(ACT_SVC_CALL, CMD_READ_INFO, 32'h0000_2000, REQUIRED_LENGTH,
                                  1'b0, '0, '0, 1'b0, 3'b000, '0));
        push_request(pack_request(ACT_SVC_CALL, CMD_READ_INFO, 32'h0400_0000, REQUIRED_LENGTH,
                                  1'b0, '0, '0, 1'b0, 3'b000, '0));
        // Timer masked off, so the service signal is taken.
        push_request(pack_request(ACT_TICK, '0, '0, '0, 1'b0, '0, '0, 1'b1, 3'b100, '0));
        push_request(pack_request(ACT_TICK, '0, '0, '0, 1'b0, '0, '0, 1'b1, 3'b111, '0));
        // Unused action with every field at its maximum.
        push_request(pack_request(ACT_UNUSED, '1, '1, '1, 1'b1, '1, '1, 1'b1, 3'b111, '1));
        push_request(pack_request(ACT_LOAD_TIMER, '0, '0, '0, 1'b0, '0, '0, 1'b0, 3'b000,
                                  64'sh7FFF_FFFF_FFFF_FFFF));
        push_request(pack_request(ACT_TICK, '0, '0, '0, 1'b0, '1, '0, 1'b0, 3'b111, '0));
        // Comparator outranks a pending service signal, which waits a tick.
        push_request(pack_request(ACT_SVC_CALL, CMD_READ_INFO, '0, REQUIRED_LENGTH,
                                  1'b0, '0, '0, 1'b0, 3'b000, '0));
        push_request(pack_request(ACT_TICK, '0, '0, '0, 1'b0, '1, '0, 1'b1, 3'b110, '0));
        push_request(pack_request(ACT_TICK, '0, '0, '0, 1'b0, '1, '0, 1'b1, 3'b100, '0));
        push_request(pack_request(ACT_SVC_CALL, '1, 32'hFFFF_F000, '1, 1'b1, '0, '0, 1'b0,
                                  3'b000, '0));
        drain();

        // Random phases, each under its own storage size and traffic mix.
        write_storage_size(32'hFFFF_FFFF);
        run_phase(150, 0, 0);
        write_storage_size(32'h0000_4000);
        run_phase(140, 75, 0);
        write_storage_size(32'h0000_0000);
        run_phase(120, 0, 75);
        write_storage_size(MEM_SIZE_RESET);
        run_phase(165, 29, 29);

        if (n_fail == 0) begin
            $display("PASS external_interrupt_and_service_call");
        end else begin
            $display("FAIL external_interrupt_and_service_call");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/eisc_pkg.sv
rtl/eisc_exec.sv
rtl/external_interrupt_and_service_call.sv
dv/tb_external_interrupt_and_service_call.sv
